### rtl/core/sbc_pkg.sv
// Shared constants and types for the segment bounce collision pipeline.
package sbc_pkg;

	localparam int COORD_WIDTH_DEFAULT = 24;
	localparam int VEL_WIDTH = 12;
	// quotient bits resolved in each divider stage
	localparam int DIV_BITS = 2;

	typedef struct packed {
		logic hit;
		logic neg_x;
		logic neg_y;
	} sbc_flags_t;

endpackage

### rtl/core/sbc_cross.sv
// Edge vectors, cross products and the denominator / numerators of the crossing test.
module sbc_cross #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [COORD_WIDTH-1:0]            wall_start_x,
	input  logic signed [COORD_WIDTH-1:0]            wall_start_y,
	input  logic signed [COORD_WIDTH-1:0]            wall_end_x,
	input  logic signed [COORD_WIDTH-1:0]            wall_end_y,
	input  logic signed [COORD_WIDTH-1:0]            pos_x,
	input  logic signed [COORD_WIDTH-1:0]            pos_y,
	input  logic signed [sbc_pkg::VEL_WIDTH-1:0]     vel_x,
	input  logic signed [sbc_pkg::VEL_WIDTH-1:0]     vel_y,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [COORD_WIDTH:0]              s10x,
	output logic signed [COORD_WIDTH:0]              s10y,
	output logic signed [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] den,
	output logic signed [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] tn,
	output logic signed [2*COORD_WIDTH+2:0]          sn,
	output logic [4*COORD_WIDTH+2*sbc_pkg::VEL_WIDTH-1:0] ctx
);

	localparam int CW   = COORD_WIDTH;
	localparam int VW   = sbc_pkg::VEL_WIDTH;
	localparam int DW   = CW + VW + 3;
	localparam int SW   = 2 * CW + 3;
	localparam int CTXW = 4 * CW + 2 * VW;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [CW:0]   s10x_s1, s10y_s1, s02x_s1, s02y_s1;
	logic signed [VW:0]   s32x_s1, s32y_s1;
	logic [CTXW-1:0]      ctx_s1, ctx_s2, ctx_s3;

	logic signed [DW-2:0] a1_s2, a2_s2, b1_s2, b2_s2;
	logic signed [SW-2:0] c1_s2, c2_s2;
	logic signed [CW:0]   s10x_s2, s10y_s2, s10x_s3, s10y_s3;

	logic signed [DW-1:0] den_s3, tn_s3;
	logic signed [SW-1:0] sn_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			s10x_s1 <= $signed({wall_end_x[CW-1], wall_end_x}) -
			           $signed({wall_start_x[CW-1], wall_start_x});
			s10y_s1 <= $signed({wall_end_y[CW-1], wall_end_y}) -
			           $signed({wall_start_y[CW-1], wall_start_y});
			s02x_s1 <= $signed({wall_start_x[CW-1], wall_start_x}) -
			           $signed({pos_x[CW-1], pos_x});
			s02y_s1 <= $signed({wall_start_y[CW-1], wall_start_y}) -
			           $signed({pos_y[CW-1], pos_y});
			s32x_s1 <= -$signed({vel_x[VW-1], vel_x});
			s32y_s1 <= -$signed({vel_y[VW-1], vel_y});
			ctx_s1  <= {wall_start_x, wall_start_y, pos_x, pos_y, vel_x, vel_y};
		end
		if (rdy_s2 && v_s1) begin
			a1_s2   <= s10x_s1 * s32y_s1;
			a2_s2   <= s32x_s1 * s10y_s1;
			b1_s2   <= s32x_s1 * s02y_s1;
			b2_s2   <= s32y_s1 * s02x_s1;
			c1_s2   <= s10x_s1 * s02y_s1;
			c2_s2   <= s10y_s1 * s02x_s1;
			s10x_s2 <= s10x_s1;
			s10y_s2 <= s10y_s1;
			ctx_s2  <= ctx_s1;
		end
		if (rdy_s3 && v_s2) begin
			den_s3  <= $signed({a1_s2[DW-2], a1_s2}) - $signed({a2_s2[DW-2], a2_s2});
			tn_s3   <= $signed({b1_s2[DW-2], b1_s2}) - $signed({b2_s2[DW-2], b2_s2});
			sn_s3   <= $signed({c1_s2[SW-2], c1_s2}) - $signed({c2_s2[SW-2], c2_s2});
			s10x_s3 <= s10x_s2;
			s10y_s3 <= s10y_s2;
			ctx_s3  <= ctx_s2;
		end
	end

	assign out_valid = v_s3;
	assign s10x      = s10x_s3;
	assign s10y      = s10y_s3;
	assign den       = den_s3;
	assign tn        = tn_s3;
	assign sn        = sn_s3;
	assign ctx       = ctx_s3;

endmodule

### rtl/core/sbc_numer.sv
// Hit decision, magnitudes and the split products that form the division numerators.
module sbc_numer #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [COORD_WIDTH:0]              s10x,
	input  logic signed [COORD_WIDTH:0]              s10y,
	input  logic signed [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] den,
	input  logic signed [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] tn,
	input  logic signed [2*COORD_WIDTH+2:0]          sn,
	input  logic [4*COORD_WIDTH+2*sbc_pkg::VEL_WIDTH-1:0] ctx_in,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output sbc_pkg::sbc_flags_t                      flags,
	output logic [2*COORD_WIDTH+sbc_pkg::VEL_WIDTH+3:0] n_x,
	output logic [2*COORD_WIDTH+sbc_pkg::VEL_WIDTH+3:0] n_y,
	output logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] mden,
	output logic [4*COORD_WIDTH+2*sbc_pkg::VEL_WIDTH-1:0] ctx
);

	localparam int CW   = COORD_WIDTH;
	localparam int VW   = sbc_pkg::VEL_WIDTH;
	localparam int DW   = CW + VW + 3;
	localparam int QW   = CW + 1;
	localparam int NW   = QW + DW;
	localparam int K    = DW / 2;
	localparam int HW   = DW - K;
	localparam int CTXW = 4 * CW + 2 * VW;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic den_neg, tn_neg, sn_neg, den_nz, sn_le, tn_le, hit_pos, hit_neg;
	logic [DW-1:0] mtn_c, mden_c;
	logic [QW-1:0] ms10x_c, ms10y_c;

	sbc_pkg::sbc_flags_t flags_s1, flags_s2, flags_s3;
	logic [DW-1:0]       mtn_s1, mden_s1, mden_s2, mden_s3;
	logic [QW-1:0]       ms10x_s1, ms10y_s1;
	logic [CTXW-1:0]     ctx_s1, ctx_s2, ctx_s3;
	logic [QW+K-1:0]     pl_x_s2, pl_y_s2;
	logic [QW+HW-1:0]    ph_x_s2, ph_y_s2;
	logic [NW-1:0]       n_x_s3, n_y_s3;

	// crossing test: inclusive bounds for a positive denominator, strict for negative
	always_comb begin
		den_neg = den[DW-1];
		tn_neg  = tn[DW-1];
		sn_neg  = sn[2*CW+2];
		den_nz  = |den;
		sn_le   = sn <= den;
		tn_le   = tn <= den;
		hit_pos = !den_neg && !sn_neg && !tn_neg && sn_le && tn_le;
		hit_neg = den_neg && sn_neg && tn_neg && !sn_le && !tn_le;
		mtn_c   = tn_neg  ? DW'(-tn)  : DW'(tn);
		mden_c  = den_neg ? DW'(-den) : DW'(den);
		ms10x_c = s10x[CW] ? QW'(-s10x) : QW'(s10x);
		ms10y_c = s10y[CW] ? QW'(-s10y) : QW'(s10y);
	end

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			flags_s1.hit   <= den_nz && (hit_pos || hit_neg);
			flags_s1.neg_x <= s10x[CW];
			flags_s1.neg_y <= s10y[CW];
			mtn_s1         <= mtn_c;
			mden_s1        <= mden_c;
			ms10x_s1       <= ms10x_c;
			ms10y_s1       <= ms10y_c;
			ctx_s1         <= ctx_in;
		end
		// split |tn| so that no single product exceeds the multiplier size
		if (rdy_s2 && v_s1) begin
			pl_x_s2  <= ms10x_s1 * mtn_s1[K-1:0];
			ph_x_s2  <= ms10x_s1 * mtn_s1[DW-1:K];
			pl_y_s2  <= ms10y_s1 * mtn_s1[K-1:0];
			ph_y_s2  <= ms10y_s1 * mtn_s1[DW-1:K];
			flags_s2 <= flags_s1;
			mden_s2  <= mden_s1;
			ctx_s2   <= ctx_s1;
		end
		if (rdy_s3 && v_s2) begin
			n_x_s3   <= {ph_x_s2, {K{1'b0}}} + NW'(pl_x_s2);
			n_y_s3   <= {ph_y_s2, {K{1'b0}}} + NW'(pl_y_s2);
			flags_s3 <= flags_s2;
			mden_s3  <= mden_s2;
			ctx_s3   <= ctx_s2;
		end
	end

	assign out_valid = v_s3;
	assign flags     = flags_s3;
	assign n_x       = n_x_s3;
	assign n_y       = n_y_s3;
	assign mden      = mden_s3;
	assign ctx       = ctx_s3;

endmodule

### rtl/core/sbc_div.sv
// Pipelined restoring divider for both axes, a few quotient bits per stage.
module sbc_div #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  sbc_pkg::sbc_flags_t                      flags_in,
	input  logic [2*COORD_WIDTH+sbc_pkg::VEL_WIDTH+3:0] n_x,
	input  logic [2*COORD_WIDTH+sbc_pkg::VEL_WIDTH+3:0] n_y,
	input  logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] mden_in,
	input  logic [4*COORD_WIDTH+2*sbc_pkg::VEL_WIDTH-1:0] ctx_in,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output sbc_pkg::sbc_flags_t                      flags,
	output logic [COORD_WIDTH:0]                     q_x,
	output logic [COORD_WIDTH:0]                     q_y,
	output logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] rem_x,
	output logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] rem_y,
	output logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] mden,
	output logic [4*COORD_WIDTH+2*sbc_pkg::VEL_WIDTH-1:0] ctx
);

	localparam int CW   = COORD_WIDTH;
	localparam int VW   = sbc_pkg::VEL_WIDTH;
	localparam int DW   = CW + VW + 3;
	localparam int QW   = CW + 1;
	localparam int NDS  = (QW + sbc_pkg::DIV_BITS - 1) / sbc_pkg::DIV_BITS;
	localparam int PW   = NDS * sbc_pkg::DIV_BITS;
	localparam int CTXW = 4 * CW + 2 * VW;

	// lq holds the unconsumed numerator bits on top and the quotient bits below
	function automatic logic [DW+PW-1:0] div_steps(
		input logic [DW-1:0] rem_in,
		input logic [PW-1:0] lq_in,
		input logic [DW-1:0] d
	);
		logic [DW-1:0] rem;
		logic [PW-1:0] lq;
		logic [DW:0]   t;
		rem = rem_in;
		lq  = lq_in;
		for (int j = 0; j < sbc_pkg::DIV_BITS; j++) begin
			t = {rem, lq[PW-1]};
			if (t >= {1'b0, d}) begin
				t  = t - {1'b0, d};
				lq = {lq[PW-2:0], 1'b1};
			end else begin
				lq = {lq[PW-2:0], 1'b0};
			end
			rem = t[DW-1:0];
		end
		return {rem, lq};
	endfunction

	logic                v_s     [NDS];
	logic                rdy     [NDS+1];
	logic [DW-1:0]       rem_x_s [NDS];
	logic [DW-1:0]       rem_y_s [NDS];
	logic [PW-1:0]       lq_x_s  [NDS];
	logic [PW-1:0]       lq_y_s  [NDS];
	logic [DW-1:0]       d_s     [NDS];
	sbc_pkg::sbc_flags_t flags_s [NDS];
	logic [CTXW-1:0]     ctx_s   [NDS];

	assign rdy[NDS] = out_ready;
	assign in_ready = rdy[0];

	for (genvar k = 0; k < NDS; k++) begin : g_stage
		logic                vin;
		logic [DW-1:0]       rem_x_in, rem_y_in, d_in, rem_x_nx, rem_y_nx;
		logic [PW-1:0]       lq_x_in, lq_y_in, lq_x_nx, lq_y_nx;
		sbc_pkg::sbc_flags_t flags_i;
		logic [CTXW-1:0]     ctx_i;

		if (k == 0) begin : g_first
			// the quotient fits in PW bits, so the top part is already below the divisor
			assign vin      = in_valid;
			assign rem_x_in = DW'(n_x >> PW);
			assign rem_y_in = DW'(n_y >> PW);
			assign lq_x_in  = PW'(n_x);
			assign lq_y_in  = PW'(n_y);
			assign d_in     = mden_in;
			assign flags_i  = flags_in;
			assign ctx_i    = ctx_in;
		end else begin : g_next
			assign vin      = v_s[k-1];
			assign rem_x_in = rem_x_s[k-1];
			assign rem_y_in = rem_y_s[k-1];
			assign lq_x_in  = lq_x_s[k-1];
			assign lq_y_in  = lq_y_s[k-1];
			assign d_in     = d_s[k-1];
			assign flags_i  = flags_s[k-1];
			assign ctx_i    = ctx_s[k-1];
		end

		assign {rem_x_nx, lq_x_nx} = div_steps(rem_x_in, lq_x_in, d_in);
		assign {rem_y_nx, lq_y_nx} = div_steps(rem_y_in, lq_y_in, d_in);
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vin) begin
				rem_x_s[k] <= rem_x_nx;
				rem_y_s[k] <= rem_y_nx;
				lq_x_s[k]  <= lq_x_nx;
				lq_y_s[k]  <= lq_y_nx;
				d_s[k]     <= d_in;
				flags_s[k] <= flags_i;
				ctx_s[k]   <= ctx_i;
			end
		end
	end

	assign out_valid = v_s[NDS-1];
	assign flags     = flags_s[NDS-1];
	assign q_x       = lq_x_s[NDS-1][QW-1:0];
	assign q_y       = lq_y_s[NDS-1][QW-1:0];
	assign rem_x     = rem_x_s[NDS-1];
	assign rem_y     = rem_y_s[NDS-1];
	assign mden      = d_s[NDS-1];
	assign ctx       = ctx_s[NDS-1];

endmodule

### rtl/core/sbc_back.sv
// Rounding, bounce position, saturation and the result register.
module sbc_back #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEFAULT
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  sbc_pkg::sbc_flags_t                      flags_in,
	input  logic [COORD_WIDTH:0]                     q_x,
	input  logic [COORD_WIDTH:0]                     q_y,
	input  logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] rem_x,
	input  logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] rem_y,
	input  logic [COORD_WIDTH+sbc_pkg::VEL_WIDTH+2:0] mden,
	input  logic [4*COORD_WIDTH+2*sbc_pkg::VEL_WIDTH-1:0] ctx_in,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic                                     hit,
	output logic signed [COORD_WIDTH-1:0]            new_pos_x,
	output logic signed [COORD_WIDTH-1:0]            new_pos_y,
	output logic signed [sbc_pkg::VEL_WIDTH-1:0]     new_vel_x,
	output logic signed [sbc_pkg::VEL_WIDTH-1:0]     new_vel_y
);

	localparam int CW   = COORD_WIDTH;
	localparam int VW   = sbc_pkg::VEL_WIDTH;
	localparam int QW   = CW + 1;
	localparam int OW   = QW + 2;
	localparam int SUMW = CW + 3;
	localparam int CTXW = 4 * CW + 2 * VW;

	function automatic logic signed [CW-1:0] sat(input logic signed [SUMW-1:0] s);
		if (s[SUMW-1:CW-1] == {(SUMW-CW+1){s[SUMW-1]}})
			return s[CW-1:0];
		else
			return s[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
	endfunction

	function automatic logic signed [VW-1:0] neg_vel(input logic signed [VW-1:0] v);
		if (v == {1'b1, {(VW-1){1'b0}}})
			return {1'b0, {(VW-1){1'b1}}};
		else
			return -v;
	endfunction

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	sbc_pkg::sbc_flags_t  flags_s1, flags_s2;
	logic [QW:0]          qr_x_s1, qr_y_s1;
	logic [CTXW-1:0]      ctx_s1, ctx_s2;
	logic signed [OW-1:0] off_x_s2, off_y_s2;
	logic signed [VW-1:0] nvx_s2, nvy_s2;

	logic                 hit_s3;
	logic signed [CW-1:0] pos_x_s3, pos_y_s3;
	logic signed [VW-1:0] vel_x_s3, vel_y_s3;

	logic                 rnd_x, rnd_y;
	logic signed [CW-1:0] wsx2, wsy2, px2, py2;
	logic signed [VW-1:0] vx1, vy1, vx2, vy2;
	logic signed [SUMW-1:0] sum_x, sum_y;

	// context layout: wall start x/y, position x/y, velocity x/y, msb first
	assign vx1  = ctx_s1[2*VW-1 -: VW];
	assign vy1  = ctx_s1[VW-1:0];
	assign wsx2 = ctx_s2[4*CW+2*VW-1 -: CW];
	assign wsy2 = ctx_s2[3*CW+2*VW-1 -: CW];
	assign px2  = ctx_s2[2*CW+2*VW-1 -: CW];
	assign py2  = ctx_s2[CW+2*VW-1 -: CW];
	assign vx2  = ctx_s2[2*VW-1 -: VW];
	assign vy2  = ctx_s2[VW-1:0];

	// round half away from zero on the magnitude
	assign rnd_x = {rem_x, 1'b0} >= {1'b0, mden};
	assign rnd_y = {rem_y, 1'b0} >= {1'b0, mden};

	assign sum_x = SUMW'(wsx2) + SUMW'(off_x_s2) + SUMW'(nvx_s2);
	assign sum_y = SUMW'(wsy2) + SUMW'(off_y_s2) + SUMW'(nvy_s2);

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			qr_x_s1  <= (QW+1)'(q_x) + (QW+1)'(rnd_x);
			qr_y_s1  <= (QW+1)'(q_y) + (QW+1)'(rnd_y);
			flags_s1 <= flags_in;
			ctx_s1   <= ctx_in;
		end
		if (rdy_s2 && v_s1) begin
			off_x_s2 <= flags_s1.neg_x ? -$signed({1'b0, qr_x_s1}) : $signed({1'b0, qr_x_s1});
			off_y_s2 <= flags_s1.neg_y ? -$signed({1'b0, qr_y_s1}) : $signed({1'b0, qr_y_s1});
			nvx_s2   <= neg_vel(vx1);
			nvy_s2   <= neg_vel(vy1);
			flags_s2 <= flags_s1;
			ctx_s2   <= ctx_s1;
		end
		// without a hit, pass position and velocity through
		if (rdy_s3 && v_s2) begin
			hit_s3   <= flags_s2.hit;
			pos_x_s3 <= flags_s2.hit ? sat(sum_x) : px2;
			pos_y_s3 <= flags_s2.hit ? sat(sum_y) : py2;
			vel_x_s3 <= flags_s2.hit ? nvx_s2 : vx2;
			vel_y_s3 <= flags_s2.hit ? nvy_s2 : vy2;
		end
	end

	assign out_valid = v_s3;
	assign hit       = hit_s3;
	assign new_pos_x = pos_x_s3;
	assign new_pos_y = pos_y_s3;
	assign new_vel_x = vel_x_s3;
	assign new_vel_y = vel_y_s3;

endmodule

### rtl/core/segment_bounce_collision.sv
// Particle versus wall-segment bounce engine, fully pipelined.
//
// Input channel (in_valid/in_ready): one wall segment and one particle (position and
// velocity, signed fixed point) per transaction. Output channel (out_valid/out_ready):
// one result per transaction, in order: hit flag, new position and new velocity.
// On a hit the velocity is negated and the particle is placed at the crossing point
// on the wall plus the new velocity, saturated; otherwise the inputs pass through.
// Throughput: one transaction per cycle while out_ready is high. The pipeline depth
// is set by the exact cross-product stages and the divider that resolves two quotient
// bits per stage.
// Every stage holds its own valid bit, so empty stages fill while the output waits:
// with out_ready low the pipeline keeps accepting until all stages are occupied,
// then in_ready drops; nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits; in_ready is high right after reset.
module segment_bounce_collision #(
	parameter int COORD_WIDTH = sbc_pkg::COORD_WIDTH_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_WIDTH-1:0]        wall_start_x,
	input  logic signed [COORD_WIDTH-1:0]        wall_start_y,
	input  logic signed [COORD_WIDTH-1:0]        wall_end_x,
	input  logic signed [COORD_WIDTH-1:0]        wall_end_y,
	input  logic signed [COORD_WIDTH-1:0]        pos_x,
	input  logic signed [COORD_WIDTH-1:0]        pos_y,
	input  logic signed [sbc_pkg::VEL_WIDTH-1:0] vel_x,
	input  logic signed [sbc_pkg::VEL_WIDTH-1:0] vel_y,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 hit,
	output logic signed [COORD_WIDTH-1:0]        new_pos_x,
	output logic signed [COORD_WIDTH-1:0]        new_pos_y,
	output logic signed [sbc_pkg::VEL_WIDTH-1:0] new_vel_x,
	output logic signed [sbc_pkg::VEL_WIDTH-1:0] new_vel_y
);

	localparam int CW   = COORD_WIDTH;
	localparam int VW   = sbc_pkg::VEL_WIDTH;
	localparam int DW   = CW + VW + 3;
	localparam int SW   = 2 * CW + 3;
	localparam int QW   = CW + 1;
	localparam int NW   = QW + DW;
	localparam int CTXW = 4 * CW + 2 * VW;

	logic                 cr_valid, cr_ready;
	logic signed [CW:0]   cr_s10x, cr_s10y;
	logic signed [DW-1:0] cr_den, cr_tn;
	logic signed [SW-1:0] cr_sn;
	logic [CTXW-1:0]      cr_ctx;

	logic                 nu_valid, nu_ready;
	sbc_pkg::sbc_flags_t  nu_flags;
	logic [NW-1:0]        nu_n_x, nu_n_y;
	logic [DW-1:0]        nu_mden;
	logic [CTXW-1:0]      nu_ctx;

	logic                 dv_valid, dv_ready;
	sbc_pkg::sbc_flags_t  dv_flags;
	logic [QW-1:0]        dv_q_x, dv_q_y;
	logic [DW-1:0]        dv_rem_x, dv_rem_y, dv_mden;
	logic [CTXW-1:0]      dv_ctx;

	sbc_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.wall_start_x (wall_start_x),
		.wall_start_y (wall_start_y),
		.wall_end_x   (wall_end_x),
		.wall_end_y   (wall_end_y),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.out_valid    (cr_valid),
		.out_ready    (cr_ready),
		.s10x         (cr_s10x),
		.s10y         (cr_s10y),
		.den          (cr_den),
		.tn           (cr_tn),
		.sn           (cr_sn),
		.ctx          (cr_ctx)
	);

	sbc_numer #(.COORD_WIDTH(COORD_WIDTH)) u_numer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cr_valid),
		.in_ready  (cr_ready),
		.s10x      (cr_s10x),
		.s10y      (cr_s10y),
		.den       (cr_den),
		.tn        (cr_tn),
		.sn        (cr_sn),
		.ctx_in    (cr_ctx),
		.out_valid (nu_valid),
		.out_ready (nu_ready),
		.flags     (nu_flags),
		.n_x       (nu_n_x),
		.n_y       (nu_n_y),
		.mden      (nu_mden),
		.ctx       (nu_ctx)
	);

	sbc_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nu_valid),
		.in_ready  (nu_ready),
		.flags_in  (nu_flags),
		.n_x       (nu_n_x),
		.n_y       (nu_n_y),
		.mden_in   (nu_mden),
		.ctx_in    (nu_ctx),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.flags     (dv_flags),
		.q_x       (dv_q_x),
		.q_y       (dv_q_y),
		.rem_x     (dv_rem_x),
		.rem_y     (dv_rem_y),
		.mden      (dv_mden),
		.ctx       (dv_ctx)
	);

	sbc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.flags_in  (dv_flags),
		.q_x       (dv_q_x),
		.q_y       (dv_q_y),
		.rem_x     (dv_rem_x),
		.rem_y     (dv_rem_y),
		.mden      (dv_mden),
		.ctx_in    (dv_ctx),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.new_pos_x (new_pos_x),
		.new_pos_y (new_pos_y),
		.new_vel_x (new_vel_x),
		.new_vel_y (new_vel_y)
	);

	// input back-pressure only appears once the whole pipeline is full behind a stalled output
	a_full_before_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the pipeline still has room");

	// a negated velocity can never be the most negative code
	a_bounce_vel_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |->
		(new_vel_x != {1'b1, {(VW-1){1'b0}}} && new_vel_y != {1'b1, {(VW-1){1'b0}}}))
		else $error("bounce velocity not saturated");

	// a particle at rest has a zero denominator and cannot hit
	a_bounce_moving: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (new_vel_x != '0 || new_vel_y != '0))
		else $error("hit reported for a particle at rest");

endmodule
